@@ hw/rtl/brle_pkg.sv @@
// Shared types, constants and a helper function of the run-length bitmap pixel decoder.
`timescale 1ns / 1ps
`default_nettype none
package brle_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Field widths of the channels.
  localparam int DATA_W    = 8;
  localparam int POS_W     = 12;
  localparam int LEN_W     = 8;
  localparam int DIM_W     = 13;
  localparam int CFG_IDX_W = 2;

  // Column counter saturates at its all-ones value.
  localparam int X_W = 13;
  localparam logic [X_W-1:0] X_LIMIT = '1;

  // Effective register limits: the smaller of the build limit and the field range.
  localparam int WIDTH_CAP  = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
  localparam int HEIGHT_CAP = (MAX_HEIGHT < 4096) ? MAX_HEIGHT : 4096;
  localparam logic [DIM_W-1:0] WIDTH_CAP_V  = DIM_W'(WIDTH_CAP);
  localparam logic [DIM_W-1:0] HEIGHT_CAP_V = DIM_W'(HEIGHT_CAP);

  // Escape codes that follow a zero count byte.
  localparam logic [DATA_W-1:0] ESC_EOL   = 8'd0;
  localparam logic [DATA_W-1:0] ESC_EOI   = 8'd1;
  localparam logic [DATA_W-1:0] ESC_DELTA = 8'd2;

  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_COUNT  = 3'd0,
    PH_COLOR  = 3'd1,
    PH_ESCAPE = 3'd2,
    PH_DX     = 3'd3,
    PH_DY     = 3'd4,
    PH_ABS    = 3'd5,
    PH_PAD    = 3'd6
  } phase_t;

  typedef struct packed {
    logic              kind;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [LEN_W-1:0]  span_len;
    logic [DATA_W-1:0] color_first;
    logic [DATA_W-1:0] color_second;
  } result_t;

  // A dimension of zero acts as one; values above the cap act as the cap.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] cap);
    logic [DIM_W-1:0] r;
    r = v;
    if (r == '0) r = DIM_W'(1);
    if (r > cap) r = cap;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/brle_in_if.sv @@
// Input channel of the decoder: one compressed byte per word.
`timescale 1ns / 1ps
`default_nettype none
interface brle_in_if;
  import brle_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              image_start;

  modport source (output valid, output data_byte, output image_start, input ready);
  modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/brle_out_if.sv @@
// Result channel of the decoder: one pixel span or finished mark per word.
`timescale 1ns / 1ps
`default_nettype none
interface brle_out_if;
  import brle_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [LEN_W-1:0]  span_len;
  logic [DATA_W-1:0] color_first;
  logic [DATA_W-1:0] color_second;

  modport source (output valid, output kind, output pos_x, output pos_y, output span_len,
                  output color_first, output color_second, input ready);
  modport sink   (input valid, input kind, input pos_x, input pos_y, input span_len,
                  input color_first, input color_second, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/brle_cfg_if.sv @@
// Configuration write channel of the decoder: register index and write data.
`timescale 1ns / 1ps
`default_nettype none
interface brle_cfg_if;
  import brle_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/bmp_rle_pixel_decoder.sv @@
// Top level of the run-length bitmap pixel decoder (8-bit and 4-bit modes).
// A byte accepted into the input register is parsed into the result register when
// the parser advances, which can stall while an earlier result word is still waiting.
// Throughput: one byte per cycle while the result side does not hold a waiting word.
// Reset: synchronous, active low; clears control state, marks the image as
// finished so bytes are ignored until one arrives with image_start set.
`timescale 1ns / 1ps
`default_nettype none
module bmp_rle_pixel_decoder (
  input  wire          clk,
  input  wire          rst_n,
  brle_in_if.sink      in_bus,
  brle_out_if.source   out_bus,
  brle_cfg_if.sink     cfg_bus
);
  import brle_pkg::*;

  // Configuration registers.
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic             mode_r;

  // Input register.
  logic              in_valid_r;
  logic [DATA_W-1:0] in_data_r;
  logic              in_start_r;

  // Parser state.
  phase_t            phase_r, phase_nxt;
  logic [X_W-1:0]    x_r, x_nxt;
  logic [POS_W-1:0]  y_r, y_nxt;
  logic [LEN_W-1:0]  pend_r, pend_nxt;
  logic [LEN_W-1:0]  abs_r, abs_nxt;
  logic              pad_r, pad_nxt;
  logic              done_r, done_nxt;

  // Result register.
  logic              out_valid_r;
  result_t           res_r;
  result_t           res_nxt;
  logic              res_valid;

  logic advance;
  logic four;
  logic [DATA_W-1:0] b;

  // State as seen by the current byte, after an image start.
  phase_t           e_phase;
  logic [X_W-1:0]   e_x;
  logic [POS_W-1:0] e_y;
  logic [LEN_W-1:0] e_pend;
  logic [LEN_W-1:0] e_abs;
  logic             e_pad;
  logic             e_done;
  logic [DIM_W-1:0] h_eff;
  logic [DIM_W-1:0] h_top;
  logic [DIM_W-1:0] w_eff;

  logic             fin;
  logic [LEN_W-1:0] abs_step;
  logic [LEN_W-1:0] abs_rem;
  logic [DATA_W:0]  b_inc;
  logic             abs_pad;

  logic             span_req;
  logic [LEN_W-1:0] span_n;
  logic [DATA_W-1:0] c1, c2;
  logic             span_ok;
  logic [DIM_W-1:0] avail;
  logic [LEN_W-1:0] span_len;

  function automatic logic [X_W-1:0] sat_add(input logic [X_W-1:0] x,
                                             input logic [LEN_W-1:0] n);
    logic [X_W:0] s;
    s = {1'b0, x} + {{(X_W+1-LEN_W){1'b0}}, n};
    return s[X_W] ? X_LIMIT : s[X_W-1:0];
  endfunction

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
      mode_r   <= 1'b0;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_WIDTH:  width_r  <= cfg_bus.data;
        REG_HEIGHT: height_r <= cfg_bus.data;
        REG_MODE:   mode_r   <= cfg_bus.data[0];
        default:    ;
      endcase
    end
  end

  assign advance      = in_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      in_data_r  <= in_bus.data_byte;
      in_start_r <= in_bus.image_start;
    end
  end

  assign four  = mode_r;
  assign b     = in_data_r;
  assign h_eff = eff_dim(height_r, HEIGHT_CAP_V);
  assign h_top = h_eff - DIM_W'(1);
  assign w_eff = eff_dim(width_r, WIDTH_CAP_V);

  assign e_phase = in_start_r ? PH_COUNT : phase_r;
  assign e_x     = in_start_r ? '0 : x_r;
  assign e_y     = in_start_r ? h_top[POS_W-1:0] : y_r;
  assign e_pend  = in_start_r ? '0 : pend_r;
  assign e_abs   = in_start_r ? '0 : abs_r;
  assign e_pad   = in_start_r ? 1'b0 : pad_r;
  assign e_done  = in_start_r ? 1'b0 : done_r;

  // End of image, end of line on the bottom row, or a delta below the bottom row.
  assign fin = !e_done &&
               (((e_phase == PH_ESCAPE) &&
                 (((b == ESC_EOL) && (e_y == '0)) || (b == ESC_EOI))) ||
                ((e_phase == PH_DY) && ({{(POS_W-DATA_W){1'b0}}, b} > e_y)));

  // Four-bit absolute runs take two pixels per byte, the last byte maybe one.
  assign abs_step = (four && (e_abs >= LEN_W'(2))) ? LEN_W'(2) : LEN_W'(1);
  assign abs_rem  = (e_abs > abs_step) ? (e_abs - abs_step) : '0;

  // Pad follows when the number of data bytes in the run is odd.
  assign b_inc   = {1'b0, b} + (DATA_W+1)'(1);
  assign abs_pad = four ? b_inc[1] : b[0];

  always_comb begin
    phase_nxt = e_phase;
    if (!e_done) begin
      if (fin) begin
        phase_nxt = PH_COUNT;
      end else begin
        case (e_phase)
          PH_COUNT:  phase_nxt = (b == '0) ? PH_ESCAPE : PH_COLOR;
          PH_COLOR:  phase_nxt = PH_COUNT;
          PH_ESCAPE: begin
            if (b == ESC_EOL)        phase_nxt = PH_COUNT;
            else if (b == ESC_DELTA) phase_nxt = PH_DX;
            else                     phase_nxt = PH_ABS;
          end
          PH_DX:     phase_nxt = PH_DY;
          PH_DY:     phase_nxt = PH_COUNT;
          PH_ABS: begin
            if (abs_rem == '0) phase_nxt = e_pad ? PH_PAD : PH_COUNT;
            else               phase_nxt = PH_ABS;
          end
          PH_PAD:    phase_nxt = PH_COUNT;
          default:   phase_nxt = PH_COUNT;
        endcase
      end
    end
  end

  always_comb begin
    x_nxt    = e_x;
    y_nxt    = e_y;
    pend_nxt = e_pend;
    abs_nxt  = e_abs;
    pad_nxt  = e_pad;
    done_nxt = e_done;
    span_req = 1'b0;
    span_n   = e_pend;
    c1       = four ? {4'b0, b[7:4]} : b;
    c2       = four ? {4'b0, b[3:0] & NIBBLE_MASK} : b;
    if (!e_done) begin
      if (fin) done_nxt = 1'b1;
      case (e_phase)
        PH_COUNT: begin
          if (b != '0) pend_nxt = b;
        end
        PH_COLOR: begin
          span_req = 1'b1;
          span_n   = e_pend;
          x_nxt    = sat_add(e_x, e_pend);
        end
        PH_ESCAPE: begin
          if (b == ESC_EOL) begin
            x_nxt = '0;
            if (e_y != '0) y_nxt = e_y - POS_W'(1);
          end else if (b > ESC_DELTA) begin
            abs_nxt = b;
            pad_nxt = abs_pad;
          end
        end
        PH_DX: begin
          x_nxt = sat_add(e_x, b);
        end
        PH_DY: begin
          if (!fin) y_nxt = e_y - {{(POS_W-DATA_W){1'b0}}, b};
        end
        PH_ABS: begin
          span_req = 1'b1;
          span_n   = abs_step;
          x_nxt    = sat_add(e_x, abs_step);
          abs_nxt  = abs_rem;
        end
        PH_PAD:  ;
        default: ;
      endcase
    end
  end

  // Clip the span at the image width.
  assign avail    = w_eff - e_x;
  assign span_len = ({{(DIM_W-LEN_W){1'b0}}, span_n} < avail) ? span_n : avail[LEN_W-1:0];
  assign span_ok  = (e_x < w_eff) && (span_len != '0);

  assign res_valid = fin || (span_req && span_ok);

  always_comb begin
    if (fin) begin
      res_nxt      = '0;
      res_nxt.kind = 1'b1;
    end else begin
      res_nxt.kind         = 1'b0;
      res_nxt.pos_x        = e_x[POS_W-1:0];
      res_nxt.pos_y        = e_y;
      res_nxt.span_len     = span_len;
      res_nxt.color_first  = c1;
      res_nxt.color_second = c2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_COUNT;
      x_r         <= '0;
      y_r         <= '0;
      pend_r      <= '0;
      abs_r       <= '0;
      pad_r       <= 1'b0;
      done_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        phase_r     <= phase_nxt;
        x_r         <= x_nxt;
        y_r         <= y_nxt;
        pend_r      <= pend_nxt;
        abs_r       <= abs_nxt;
        pad_r       <= pad_nxt;
        done_r      <= done_nxt;
        out_valid_r <= res_valid;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) res_r <= res_nxt;
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.kind         = res_r.kind;
  assign out_bus.pos_x        = res_r.pos_x;
  assign out_bus.pos_y        = res_r.pos_y;
  assign out_bus.span_len     = res_r.span_len;
  assign out_bus.color_first  = res_r.color_first;
  assign out_bus.color_second = res_r.color_second;

  // An absolute run in progress always has pixels left.
  a_abs_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ABS) |-> (abs_r != '0))
    else $error("absolute run phase with no pixels left");

  // A finishing byte leaves the parser idle.
  a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && fin) |=> (done_r && (phase_r == PH_COUNT)))
    else $error("finish did not mark the image done");

  // An idle parser gives no word for a byte without image start.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && done_r && !in_start_r) |=> !out_valid_r)
    else $error("result produced while idle");

  // Every span word carries at least one pixel.
  a_span_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.kind) |-> (res_r.span_len != '0))
    else $error("empty span delivered");

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench of the run-length bitmap pixel decoder.
`timescale 1ns / 1ps
module tb_top;
  import brle_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned REPORT_MAX  = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Software image of the decoder: parser state, registers and the spans still owed.
  class span_scoreboard;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             four_bit;
    phase_t           phase;
    logic [X_W-1:0]   col;
    logic [DIM_W-1:0] row;
    logic [7:0]       run_count;
    logic [7:0]       abs_left;
    logic             pad_due;
    logic             done;
    result_t          expected_spans[$];
    int unsigned      mismatches;

    function new();
      width_reg  = 13'd1;
      height_reg = 13'd1;
      four_bit   = 1'b0;
      phase      = PH_COUNT;
      col        = '0;
      row        = '0;
      run_count  = '0;
      abs_left   = '0;
      pad_due    = 1'b0;
      done       = 1'b1;
      mismatches = 0;
    endfunction

    function logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
      if (v == '0) return 13'd1;
      if (v > 13'd4096) return 13'd4096;
      return v;
    endfunction

    function void write_field(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
      if (idx == REG_WIDTH) width_reg = v;
      else if (idx == REG_HEIGHT) height_reg = v;
      else if (idx == REG_MODE) four_bit = v[0];
    endfunction

    function void step_col(logic [8:0] n);
      logic [X_W:0] s;
      s = {1'b0, col} + n;
      col = (s > {1'b0, X_LIMIT}) ? X_LIMIT : s[X_W-1:0];
    endfunction

    // Clips a span against the row width; no word when nothing is left.
    function bit clip_span(logic [8:0] n, logic [7:0] c1, logic [7:0] c2,
                           output result_t r);
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] avail;
      logic [DIM_W-1:0] len;
      r = '0;
      w = clamp_dim(width_reg);
      if (col >= w) return 0;
      avail = w - col;
      len = ({4'd0, n} < avail) ? {4'd0, n} : avail;
      if (len == '0) return 0;
      r.kind = 1'b0;
      r.pos_x = col[POS_W-1:0];
      r.pos_y = row[POS_W-1:0];
      r.span_len = len[LEN_W-1:0];
      r.color_first = c1;
      r.color_second = c2;
      return 1;
    endfunction

    function result_t finish_mark();
      result_t r;
      r = '0;
      r.kind = 1'b1;
      done = 1'b1;
      phase = PH_COUNT;
      return r;
    endfunction

    function void note_byte(logic [7:0] b, logic st);
      result_t r;
      bit has;
      logic [8:0] n;
      has = 0;
      r = '0;
      if (st) begin
        phase = PH_COUNT;
        col = '0;
        row = clamp_dim(height_reg) - 13'd1;
        run_count = '0;
        abs_left = '0;
        pad_due = 1'b0;
        done = 1'b0;
      end
      if (done) return;
      case (phase)
        PH_COUNT: begin
          if (b == 8'd0) phase = PH_ESCAPE;
          else begin
            run_count = b;
            phase = PH_COLOR;
          end
        end
        PH_COLOR: begin
          if (four_bit) has = clip_span({1'b0, run_count}, {4'd0, b[7:4]}, {4'd0, b[3:0]}, r);
          else has = clip_span({1'b0, run_count}, b, b, r);
          step_col({1'b0, run_count});
          phase = PH_COUNT;
        end
        PH_ESCAPE: begin
          if (b == ESC_EOL) begin
            col = '0;
            if (row == '0) begin
              r = finish_mark();
              has = 1;
            end else begin
              row = row - 13'd1;
              phase = PH_COUNT;
            end
          end else if (b == ESC_EOI) begin
            r = finish_mark();
            has = 1;
          end else if (b == ESC_DELTA) begin
            phase = PH_DX;
          end else begin
            abs_left = b;
            n = four_bit ? (({1'b0, b} + 9'd1) >> 1) : {1'b0, b};
            pad_due = n[0];
            phase = PH_ABS;
          end
        end
        PH_DX: begin
          step_col({1'b0, b});
          phase = PH_DY;
        end
        PH_DY: begin
          if ({5'd0, b} > row) begin
            r = finish_mark();
            has = 1;
          end else begin
            row = row - {5'd0, b};
            phase = PH_COUNT;
          end
        end
        PH_ABS: begin
          if (four_bit) begin
            n = (abs_left >= 8'd2) ? 9'd2 : 9'd1;
            has = clip_span(n, {4'd0, b[7:4]}, {4'd0, b[3:0] & NIBBLE_MASK}, r);
          end else begin
            n = 9'd1;
            has = clip_span(n, b, b, r);
          end
          step_col(n);
          abs_left = ({1'b0, abs_left} > n) ? abs_left - n[7:0] : 8'd0;
          if (abs_left == 8'd0) phase = pad_due ? PH_PAD : PH_COUNT;
        end
        default: phase = PH_COUNT;
      endcase
      if (has) expected_spans.push_back(r);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: unexpected word kind=%0d x=%0d y=%0d len=%0d c=%h/%h",
                   got.kind, got.pos_x, got.pos_y, got.span_len,
                   got.color_first, got.color_second);
        return;
      end
      want = expected_spans.pop_front();
      if (got.kind !== want.kind || got.pos_x !== want.pos_x ||
          got.pos_y !== want.pos_y || got.span_len !== want.span_len ||
          got.color_first !== want.color_first ||
          got.color_second !== want.color_second) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: expected kind=%0d x=%0d y=%0d len=%0d c=%h/%h, got kind=%0d x=%0d y=%0d len=%0d c=%h/%h",
                   want.kind, want.pos_x, want.pos_y, want.span_len,
                   want.color_first, want.color_second,
                   got.kind, got.pos_x, got.pos_y, got.span_len,
                   got.color_first, got.color_second);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  brle_in_if  in_bus();
  brle_out_if out_bus();
  brle_cfg_if cfg_bus();

  bmp_rle_pixel_decoder DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  span_scoreboard board = new();

  bit          idle_on;
  logic        start_next;
  logic        four_bit_now;
  int unsigned sent_items;
  int unsigned cycles = 0;
  int          stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watch every handshake at the rising edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) board.write_field(cfg_bus.index, cfg_bus.data);
      if (in_bus.valid && in_bus.ready) board.note_byte(in_bus.data_byte, in_bus.image_start);
      if (out_bus.valid && out_bus.ready) begin
        board.check_word('{kind: out_bus.kind, pos_x: out_bus.pos_x, pos_y: out_bus.pos_y,
                           span_len: out_bus.span_len, color_first: out_bus.color_first,
                           color_second: out_bus.color_second});
      end
    end
  end

  // Result side stalls in bursts, each started at random while idle_on is set.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_bus.ready = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_bus.ready = 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_bus.ready = 1'b1;
    end
  end

  // Leaves valid high on return so back-to-back words keep flowing.
  task automatic push_byte(input logic [7:0] b, input logic st);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.data_byte = b;
    in_bus.image_start = st;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic put(input logic [7:0] b);
    push_byte(b, start_next);
    start_next = 1'b0;
    sent_items++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data = v;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
    if (idx == REG_MODE) four_bit_now = v[0];
  endtask

  // Wait for all owed words, then let bytes that owe none work through the pipeline.
  task automatic settle();
    in_bus.valid = 1'b0;
    while (board.expected_spans.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic m);
    settle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_MODE, {12'd0, m});
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(0, 11);
    if (sel == 0) return 13'd0;
    if (sel == 1) return 13'd4096;
    if (sel == 2) return DIM_W'($urandom_range(4097, 8191));
    return DIM_W'($urandom_range(1, 24));
  endfunction

  // One image of mostly well-formed commands with random content and some noise.
  task automatic run_image();
    int ops;
    int k;
    int sel;
    int n;
    int nbytes;
    int j;
    start_next = 1'b1;
    ops = $urandom_range(2, 10);
    for (k = 0; k < ops; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        if ($urandom_range(0, 9) == 0) put(8'($urandom_range(1, 255)));
        else put(8'($urandom_range(1, 20)));
        put(8'($urandom));
      end else if (sel < 60) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 14);
        put(8'd0);
        put(8'(n));
        nbytes = four_bit_now ? (n + 1) / 2 : n;
        for (j = 0; j < nbytes; j++) put(8'($urandom));
        if (nbytes % 2 == 1) put(8'($urandom));
      end else if (sel < 75) begin
        put(8'd0);
        put(ESC_EOL);
      end else if (sel < 88) begin
        put(8'd0);
        put(ESC_DELTA);
        put(($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)));
        put(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2)));
      end else begin
        // A stray byte, now and then restarting the image in mid-command.
        push_byte(8'($urandom), ($urandom_range(0, 2) == 0));
        start_next = 1'b0;
        sent_items++;
      end
    end
    if ($urandom_range(0, 4) != 0) begin
      put(8'd0);
      put(ESC_EOI);
      if ($urandom_range(0, 3) == 0) push_byte(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    int p;
    int unsigned quota;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.data_byte = '0;
    in_bus.image_start = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    out_bus.ready = 1'b1;
    idle_on = 1'b1;
    start_next = 1'b0;
    four_bit_now = 1'b0;
    sent_items = 0;
    stall_left = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, eight-bit mode. A byte after reset without a start is ignored.
    push_byte(8'hFF, 1'b0);
    settle();
    write_reg(REG_UNUSED, 13'd5);
    configure(13'd16, 13'd2, 1'b0);
    push_byte(8'h03, 1'b1);
    push_byte(8'hAB, 1'b0);
    // Long run clipped at the width, then a run that starts past it.
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(ESC_EOL, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(ESC_DELTA, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(8'h00, 1'b0);
    // Odd absolute run with its pad byte.
    push_byte(8'h00, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);
    push_byte(8'hEE, 1'b0);
    // End of line on the bottom row finishes the image; the next byte is ignored.
    push_byte(8'h00, 1'b0);
    push_byte(ESC_EOL, 1'b0);
    push_byte(8'h01, 1'b0);

    // Four-bit mode: alternating run, odd absolute run, delta below the bottom row.
    configure(13'd16, 13'd3, 1'b1);
    push_byte(8'h05, 1'b1);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'h77, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(ESC_DELTA, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(ESC_EOI, 1'b0);

    sent_items = 0;
    for (p = 0; p < 8; p++) begin
      idle_on = (p != 7) && ($urandom_range(0, 3) != 0);
      case (p)
        0: configure(13'd4096, 13'd4096, 1'b0);
        1: configure(13'd1, 13'd1, 1'b1);
        2: configure(13'd0, 13'd0, 1'b0);
        3: configure(13'd8191, 13'd8191, 1'b1);
        default: configure(pick_dim(), pick_dim(), 1'($urandom_range(0, 1)));
      endcase
      quota = (p + 1) * 100;
      while (sent_items < quota) run_image();
    end

    settle();
    repeat (8) @(negedge clk);
    if (board.mismatches == 0 && board.expected_spans.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/brle_pkg.sv
hw/rtl/brle_in_if.sv
hw/rtl/brle_out_if.sv
hw/rtl/brle_cfg_if.sv
hw/rtl/bmp_rle_pixel_decoder.sv
test/tb_top.sv
